@@ design/orcg_pkg.sv @@
`default_nettype none
package orcg_pkg;

  localparam int MAX_RADIUS = 63;
  localparam int COORD_BITS = 15;

  localparam int COL_W    = 15;
  localparam int ROW_W    = 15;
  localparam int RAD_W    = 6;
  localparam int STRIDE_W = 16;
  localparam int IDX_W    = 31;
  localparam int STEP_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0]    origin_col;
    logic [ROW_W-1:0]    origin_row;
    logic [RAD_W-1:0]    view_radius;
    logic [STRIDE_W-1:0] row_stride;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fail;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/octant_ray_cell_generator.sv @@
`default_nettype none
// walks one bresenham ray per item from the origin toward (origin_col + r, origin_row + radius)
// and emits the linear index of every cell inside the radius, the final one flagged by last;
// an out-of-range or cell-less ray gives a single result with empty_ray set. rays are taken
// one at a time: each ray takes an accept step, one walk step per cell and one closing step;
// an empty ray takes only the accept and the closing step. a stalled output holds the walk.
// the next ray is accepted as soon as the previous one has pushed its last result into the
// output register.
module octant_ray_cell_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [orcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [orcg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [orcg_pkg::RAD_W-1:0]      ray_number,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [orcg_pkg::IDX_W-1:0]           cell_index,
  output logic [orcg_pkg::STEP_W-1:0]          step_number,
  output logic                                 empty_ray,
  output logic                                 last
);
  import orcg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  orcg_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  orcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  orcg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ray_number  (ray_number),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_index  (cell_index),
    .step_number (step_number),
    .empty_ray   (empty_ray),
    .last        (last)
  );

  a_push_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance || cmd.finish) |-> status.out_free)
    else $error("walk step taken with output slot occupied");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (in_ready && out_valid && last))
    else $error("ray finish did not leave a last result and an idle controller");

  a_idle_no_walk: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.advance || cmd.finish))
    else $error("walk command while idle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_ray) |-> last)
    else $error("empty result not flagged last");

endmodule
`default_nettype wire

@@ design/orcg_cfg.sv @@
`default_nettype none
module orcg_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [orcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [orcg_pkg::CFG_DATA_W-1:0] cfg_data,
  output orcg_pkg::cfg_t                       cfg
);
  import orcg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_col  <= '0;
      cfg.origin_row  <= '0;
      cfg.view_radius <= RAD_W'(8);
      cfg.row_stride  <= STRIDE_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ORIGIN_COL:  cfg.origin_col  <= cfg_data[COL_W-1:0];
        REG_ORIGIN_ROW:  cfg.origin_row  <= cfg_data[ROW_W-1:0];
        REG_VIEW_RADIUS: cfg.view_radius <= cfg_data[RAD_W-1:0];
        REG_ROW_STRIDE:  cfg.row_stride  <= cfg_data[STRIDE_W-1:0];
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/orcg_ctrl.sv @@
`default_nettype none
module orcg_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire orcg_pkg::status_t status,
  output orcg_pkg::cmd_t    cmd
);
  import orcg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // every walk cycle may push a result, so wait for a free output slot
        if (status.out_free) begin
          if (status.fail) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ design/orcg_datapath.sv @@
`default_nettype none
module orcg_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire orcg_pkg::cfg_t               cfg,
  input  wire logic [orcg_pkg::RAD_W-1:0]   ray_number,
  input  wire orcg_pkg::cmd_t               cmd,
  output orcg_pkg::status_t                 status,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [orcg_pkg::IDX_W-1:0]        cell_index,
  output logic [orcg_pkg::STEP_W-1:0]       step_number,
  output logic                              empty_ray,
  output logic                              last
);
  import orcg_pkg::*;

  localparam logic [ROW_W-1:0] COORD_MASK = ROW_W'((1 << COORD_BITS) - 1);

  logic [RAD_W-1:0]      ray;
  logic [RAD_W-1:0]      rad;
  logic [2*RAD_W-1:0]    rad_sq;
  logic                  bad;
  logic [RAD_W:0]        row;
  logic [RAD_W-1:0]      col;
  logic [RAD_W:0]        rem;
  logic [IDX_W-1:0]      row_acc;
  logic [COL_W:0]        col_acc;
  logic [STEP_W-1:0]     count;
  logic                  h_valid;
  logic [IDX_W-1:0]      h_idx;
  logic [STEP_W-1:0]     h_step;

  logic [RAD_W-1:0]      rad_eff;
  logic [RAD_W:0]        row_n;
  logic [RAD_W:0]        rem_t;
  logic [RAD_W:0]        rem_n;
  logic                  step_col;
  logic                  col_inc;
  logic [RAD_W-1:0]      col_n;
  logic [2*RAD_W+1:0]    row_sq;
  logic [2*RAD_W-1:0]    col_sq;
  logic [2*RAD_W+1:0]    sq_sum;
  logic [IDX_W-1:0]      row_acc_n;
  logic [COL_W:0]        col_acc_n;
  logic [IDX_W-1:0]      idx;
  logic                  push;

  assign rad_eff = (cfg.view_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : cfg.view_radius;

  // one bresenham step from the registered position
  assign row_n    = row + (RAD_W+1)'(1);
  assign rem_t    = rem + {1'b0, ray};
  assign step_col = (rem_t >= {1'b0, rad});
  assign rem_n    = step_col ? (rem_t - {1'b0, rad}) : rem_t;
  assign col_inc  = step_col && (ray != '0);
  assign col_n    = col + RAD_W'(col_inc);

  assign row_sq = (2*RAD_W+2)'(row_n) * (2*RAD_W+2)'(row_n);
  assign col_sq = (2*RAD_W)'(col_n) * (2*RAD_W)'(col_n);
  assign sq_sum = row_sq + (2*RAD_W+2)'(col_sq);

  // row base tracks (origin_row + row) * stride, column base origin_col + col
  assign row_acc_n = row_acc + IDX_W'(cfg.row_stride);
  assign col_acc_n = col_acc + (COL_W+1)'(col_inc);
  assign idx       = row_acc_n + IDX_W'(col_acc_n);

  assign status.fail     = bad || (sq_sum > (2*RAD_W+2)'(rad_sq));
  assign status.out_free = !out_valid || out_ready;

  assign push = (cmd.advance && h_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ray     <= ray_number;
      rad     <= rad_eff;
      rad_sq  <= (2*RAD_W)'(rad_eff) * (2*RAD_W)'(rad_eff);
      bad     <= (rad_eff == '0) || (ray_number > rad_eff);
      row     <= '0;
      col     <= '0;
      rem     <= (RAD_W+1)'(rad_eff >> 1);
      row_acc <= IDX_W'(cfg.origin_row & COORD_MASK) * IDX_W'(cfg.row_stride);
      col_acc <= (COL_W+1)'(cfg.origin_col & COORD_MASK);
      count   <= '0;
    end else if (cmd.advance) begin
      row     <= row_n;
      col     <= col_n;
      rem     <= rem_n;
      row_acc <= row_acc_n;
      col_acc <= col_acc_n;
      count   <= count + STEP_W'(1);
      h_idx   <= idx;
      h_step  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (cmd.start || cmd.finish) begin
      h_valid <= 1'b0;
    end else if (cmd.advance) begin
      h_valid <= 1'b1;
    end
  end

  // held cell goes out once the next cell shows whether it was the last
  always_ff @(posedge clk) begin
    if (push) begin
      if (cmd.finish && !h_valid) begin
        cell_index  <= '0;
        step_number <= '0;
        empty_ray   <= 1'b1;
      end else begin
        cell_index  <= h_idx;
        step_number <= h_step;
        empty_ray   <= 1'b0;
      end
      last <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
